// ===== rtl/gbp_pkg.sv =====
package gbp_pkg;

    // two-bit counter value after reset: strongly taken
    localparam logic [1:0] CTR_INIT = 2'b11;

    // controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_WRITE
    } gbp_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic clr_en;   // write reset value at clear pointer, advance pointer
        logic load;     // capture an input transaction
        logic upd;      // train counter, shift history, load result register
    } gbp_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic clr_last; // clear pointer is at the last row
        logic out_free; // result register can take a new result this cycle
    } gbp_status_t;

endpackage

// ===== rtl/gbp_ctrl.sv =====
module gbp_ctrl
    import gbp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  gbp_status_t status,
    output gbp_cmd_t    cmd
);

    gbp_state_t state_reg;
    gbp_state_t state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (status.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                if (status.out_free) begin
                    state_next = s_tvalid ? ST_READ : ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clr_en = 1'b1;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            ST_READ: begin
                cmd = '0;
            end
            ST_WRITE: begin
                // finishing a branch and taking the next one share the cycle
                cmd.upd  = status.out_free;
                s_tready = status.out_free;
                cmd.load = status.out_free & s_tvalid;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/gbp_datapath.sv =====
module gbp_datapath
    import gbp_pkg::*;
#(
    parameter int PC_BITS   = 4,
    parameter int HIST_BITS = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  gbp_cmd_t    cmd,
    output gbp_status_t status,
    input  logic [31:0] branch_pc,
    input  logic        taken,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        predict_taken,
    output logic        mispredict
);

    localparam int ADDR_W = PC_BITS + HIST_BITS;
    localparam longint unsigned DEPTH = 64'd1 << ADDR_W;

    logic [1:0]           mem_q [0:DEPTH-1];
    logic [1:0]           rd_data_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [ADDR_W-1:0]    addr_next;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [HIST_BITS-1:0] hist_reg;
    logic [HIST_BITS-1:0] hist_next;
    logic                 taken_reg;
    logic [1:0]           ctr_new;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [1:0]           wr_data;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 pred_reg;
    logic                 misp_reg;

    // history shift: newest outcome enters at the top bit
    always_comb begin
        hist_next = hist_reg;
        if (cmd.upd) begin
            hist_next = (hist_reg >> 1)
                      | (HIST_BITS'(taken_reg) << (HIST_BITS - 1));
        end
    end

    // row of the table: low pc bits above the history
    assign addr_next = {branch_pc[PC_BITS-1:0], hist_next};

    // counter training
    always_comb begin
        if (rd_data_reg[0] == taken_reg) begin
            ctr_new = {taken_reg, rd_data_reg[0]};
        end else begin
            ctr_new = {rd_data_reg[1], taken_reg};
        end
    end

    // single write port shared by the clearing pass and training
    assign wr_en   = cmd.clr_en | cmd.upd;
    assign wr_addr = cmd.clr_en ? clr_addr_reg : addr_reg;
    assign wr_data = cmd.clr_en ? CTR_INIT : ctr_new;

    // counter table
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_q[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_q[addr_reg];
    end

    // control state: history, clear pointer, result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg      <= '1;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            hist_reg      <= hist_next;
            out_valid_reg <= out_valid_next;
            if (cmd.clr_en) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
        end
    end

    // captured transaction and result payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            addr_reg  <= addr_next;
            taken_reg <= taken;
        end
        if (cmd.upd) begin
            pred_reg <= rd_data_reg[1];
            misp_reg <= rd_data_reg[1] ^ taken_reg;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.upd) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end
    end

    assign status.clr_last = (clr_addr_reg == '1);
    assign status.out_free = ~out_valid_reg | out_ready;

    assign out_valid     = out_valid_reg;
    assign predict_taken = pred_reg;
    assign mispredict    = misp_reg;

endmodule

// ===== rtl/gselect_branch_predictor.sv =====
// gselect branch predictor with two-bit counters
//
// slave channel: one transaction per resolved branch, s_tdata carries the
// branch pc and the actual outcome. master channel: one transaction per
// branch with the prediction read before training and a mispredict flag.
//
// each branch reads its counter row ({pc low bits, global history}) from a
// table with a single write port, then trains the counter and shifts the
// outcome into the history. a branch goes through a registered table read,
// then write-back; the next branch is taken in the write-back cycle of the
// last one, once the result register is free.
//
// after reset the history is all ones and a clearing pass writes binary 11
// into every counter, one row a cycle, 2**(PC_BITS+HIST_BITS) rows
// (64 by default); s_tready stays low until it ends.
// a stalled receiver holds the result register; one further branch may be
// read meanwhile, and it waits in write-back until the register frees.
module gselect_branch_predictor
    import gbp_pkg::*;
#(
    parameter int PC_BITS   = 4,
    parameter int HIST_BITS = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // [31:0] branch_pc, [32] taken, [39:33] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata   // [0] predict_taken, [1] mispredict, [7:2] zero
);

    gbp_cmd_t    cmd;
    gbp_status_t status;
    logic        predict_taken;
    logic        mispredict;

    // sequencing
    gbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // table, history and result register
    gbp_datapath #(
        .PC_BITS   (PC_BITS),
        .HIST_BITS (HIST_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .branch_pc     (s_tdata[31:0]),
        .taken         (s_tdata[32]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .predict_taken (predict_taken),
        .mispredict    (mispredict)
    );

    assign m_tdata = {6'b0, mispredict, predict_taken};

endmodule
